@@ design/lfo_pkg.sv @@
package lfo_pkg;

    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int PER_W      = 24;
    localparam int AMP_W      = 17;
    localparam int DIV_DW     = 49;
    localparam int MUL_W      = 26;

    localparam logic [AMP_W-1:0] AMP_ONE = 17'd65536;

    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
    localparam logic [31:0] LFSR_SEED = 32'h1D87_2B41;

    localparam longint unsigned Q30_ONE = 64'd1073741824;
    localparam longint unsigned PI_Q30  = 64'd3373259426;

    // series divisors: (2n)(2n+1) for the sine, n for the exponent
    localparam longint unsigned SIN_DEN [1:7] = '{6, 20, 42, 72, 110, 156, 210};
    localparam longint unsigned EXP_DEN [1:16] =
        '{1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16};

    localparam logic [3:0] WAVE_SINE     = 4'd0;
    localparam logic [3:0] WAVE_TRIANGLE = 4'd1;
    localparam logic [3:0] WAVE_SAW      = 4'd2;
    localparam logic [3:0] WAVE_REV_SAW  = 4'd3;
    localparam logic [3:0] WAVE_SQUARE   = 4'd4;
    localparam logic [3:0] WAVE_EXP      = 4'd5;
    localparam logic [3:0] WAVE_RND_HOLD = 4'd6;
    localparam logic [3:0] WAVE_RND_SLID = 4'd7;
    localparam logic [3:0] WAVE_RND_TICK = 4'd8;
    localparam logic [3:0] WAVE_PULSE_UP = 4'd9;
    localparam logic [3:0] WAVE_PULSE_DN = 4'd10;

    localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_BOUND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_BOUND  = 3'd4;

    function automatic logic [AMP_W-1:0] clamp_amp(input logic signed [19:0] v);
        logic [AMP_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > 20'sd65536)
            r = AMP_ONE;
        else
            r = v[AMP_W-1:0];
        return r;
    endfunction

    function automatic logic [31:0] lfsr_adv(input logic [31:0] s);
        logic [31:0] r;
        r = {1'b0, s[31:1]} ^ (s[0] ? LFSR_TAPS : 32'd0);
        return r;
    endfunction

endpackage

@@ design/lfo_if.sv @@
interface lfo_in_if;
    import lfo_pkg::*;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] time_in_bars;
    modport source (output valid, output time_in_bars, input ready);
    modport sink   (input valid, input time_in_bars, output ready);
endinterface

interface lfo_out_if #(parameter int VW = 17);
    logic          valid;
    logic          ready;
    logic [VW-1:0] value;
    logic          new_period;
    modport source (output valid, output value, output new_period, input ready);
    modport sink   (input valid, input value, input new_period, output ready);
endinterface

interface lfo_cfg_if;
    import lfo_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/lfo_divider.sv @@
module lfo_divider
    import lfo_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_DW-1:0] dividend,
    input  logic [PER_W-1:0]  divisor,
    output logic              done,
    output logic [DIV_DW-1:0] quotient,
    output logic [PER_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(DIV_DW + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DIV_DW-1:0] q_reg, q_next;
    logic [PER_W-1:0]  r_reg, r_next;
    logic [PER_W-1:0]  d_reg, d_next;
    logic [PER_W:0]    trial;

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        trial     = {r_reg, q_reg[DIV_DW-1]};
        if (start)
        begin
            cnt_next = CNT_W'(DIV_DW);
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
            if (trial >= {1'b0, d_reg})
            begin
                r_next = PER_W'(trial - {1'b0, d_reg});
                q_next = {q_reg[DIV_DW-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[PER_W-1:0];
                q_next = {q_reg[DIV_DW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

@@ design/lfo_mult.sv @@
module lfo_mult
    import lfo_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_W-1:0]   a,
    input  logic signed [MUL_W-1:0]   b,
    output logic signed [2*MUL_W-1:0] prod
);

    logic signed [2*MUL_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

@@ design/lfo_shape_rom.sv @@
module lfo_shape_rom
    import lfo_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
)
(
    input  logic                                 sel_exp,
    input  logic [$clog2(TABLE_ENTRIES+1)-1:0]   idx,
    output logic [AMP_W-1:0]                     data
);

    function automatic longint unsigned sine_sample(input longint unsigned k);
        longint unsigned a, a2, term, s, sq;
        longint          sum;
        a    = (PI_Q30 * k) / (2 * TABLE_ENTRIES);
        a2   = (a * a) >> 30;
        term = a;
        sum  = longint'(a);
        for (int n = 1; n <= 7; n++)
        begin
            term = ((term * a2) >> 30) / SIN_DEN[n];
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        s  = longint'(sum);
        sq = (s * s + (64'd1 << 43)) >> 44;
        return (sq > 64'd65536) ? 64'd65536 : sq;
    endfunction

    function automatic longint unsigned exp_q30(input longint unsigned k);
        longint unsigned x, term, sum;
        x    = (k << 30) / TABLE_ENTRIES;
        term = Q30_ONE;
        sum  = Q30_ONE;
        for (int n = 1; n <= 16; n++)
        begin
            term = ((term * x) >> 30) / EXP_DEN[n];
            sum  = sum + term;
        end
        return sum;
    endfunction

    localparam longint unsigned ExpDen = exp_q30(TABLE_ENTRIES) - Q30_ONE;

    function automatic longint unsigned exp_sample(input longint unsigned k);
        longint unsigned num, e;
        num = (exp_q30(k) - Q30_ONE) << 16;
        e   = (num + ExpDen / 2) / ExpDen;
        return (e > 64'd65536) ? 64'd65536 : e;
    endfunction

    logic [AMP_W-1:0] sin_tab [TABLE_ENTRIES+1];
    logic [AMP_W-1:0] exp_tab [TABLE_ENTRIES+1];

    for (genvar k = 0; k <= TABLE_ENTRIES; k++)
    begin : g_tab
        localparam logic [AMP_W-1:0] SinVal = AMP_W'(sine_sample(longint'(k)));
        localparam logic [AMP_W-1:0] ExpVal = AMP_W'(exp_sample(longint'(k)));
        assign sin_tab[k] = SinVal;
        assign exp_tab[k] = ExpVal;
    end

    assign data = sel_exp ? exp_tab[idx] : sin_tab[idx];

endmodule

@@ design/lfo_waveform_generator.sv @@
// Low-frequency oscillator, control rate.
// din carries one item per update: time_in_bars, unsigned Q16.16 bars.
// dout returns one item per input: value (VALUE_FRAC_BITS+1 bits, the
// shaped waveform mapped between lower and upper bound) and new_period.
// cfg writes the registers: 0 waveform, 1 period_scale, 2 phase_offset,
// 3 lower_bound, 4 upper_bound; cfg.ready is always high.
// One item at a time: din.ready is high only while the sequencer is idle.
// Most of an item's time from acceptance to dout.valid goes to
// two passes of the 49-step radix-2 divider (current and previous time
// over the period); the shared 26x26 multiplier is registered and is
// used for phase, table index, interpolation, slide and mapping.
// dout is a holding register: a result may wait there while the next item
// is accepted; if it is still not taken when the next result is ready the
// sequencer waits in its last state.
// Reset loads the register defaults, clears previous time and the random
// slide state and seeds the noise generator; no item is in flight after it.
module lfo_waveform_generator
    import lfo_pkg::*;
#(
    parameter int VALUE_FRAC_BITS = 16,
    parameter int TABLE_ENTRIES   = 256
)
(
    input  logic         clk,
    input  logic         rst_n,
    lfo_in_if.sink       din,
    lfo_out_if.source    dout,
    lfo_cfg_if.sink      cfg
);

    localparam int VW = VALUE_FRAC_BITS + 1;
    localparam int IW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [24:0] ONE_EXT = 25'd1 << VALUE_FRAC_BITS;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_SHIFT = 13'b0000000000010,
        ST_DIVC  = 13'b0000000000100,
        ST_DIVP  = 13'b0000000001000,
        ST_SHAPE = 13'b0000000010000,
        ST_TIDX  = 13'b0000000100000,
        ST_TLO   = 13'b0000001000000,
        ST_THI   = 13'b0000010000000,
        ST_TINT  = 13'b0000100000000,
        ST_SLMUL = 13'b0001000000000,
        ST_SLADD = 13'b0010000000000,
        ST_MAP   = 13'b0100000000000,
        ST_OUT   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [3:0]               wave_reg, wave_next;
    logic [PER_W-1:0]         per_reg, per_next;
    logic signed [16:0]       phase_reg, phase_next;
    logic [16:0]              lob_reg, lob_next;
    logic [16:0]              upb_reg, upb_next;

    logic [TIME_W-1:0]        t_reg, t_next;
    logic [TIME_W-1:0]        prev_reg, prev_next;
    logic [40:0]              shift_reg, shift_next;
    logic [DIV_DW-1:0]        qc_reg, qc_next;
    logic                     rcnz_reg, rcnz_next;
    logic                     np_reg, np_next;
    logic signed [17:0]       span_reg, span_next;
    logic [16:0]              base_reg, base_next;
    logic [31:0]              lfsr_reg, lfsr_next;
    logic [AMP_W-1:0]         amp_reg, amp_next;
    logic [IW-1:0]            idx_reg, idx_next;
    logic [15:0]              fr_reg, fr_next;
    logic [AMP_W-1:0]         tlo_reg, tlo_next;
    logic                     ge_reg, ge_next;
    logic                     ov_reg, ov_next;
    logic [17:0]              val_reg, val_next;
    logic                     onp_reg, onp_next;

    logic [PER_W-1:0]          per_eff;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] prod;
    logic signed [2*MUL_W-1:0] shift_full;
    logic                      div_start, div_done;
    logic [DIV_DW-1:0]         div_dividend, div_q;
    logic [PER_W-1:0]          div_r;
    logic [AMP_W-1:0]          rom_data;
    logic [15:0]               p;
    logic [AMP_W-1:0]          g, gm;
    logic [31:0]               lfsr_step;
    logic [15:0]               rnd;
    logic [49:0]               np_lim;
    logic signed [19:0]        old_tgt;
    logic signed [19:0]        span_hold;
    logic signed [2*MUL_W-1:0] prod_adj;
    logic signed [2*MUL_W-1:0] prod_q;
    logic [17:0]               lo_c, hi_c, bdiff, rnd_map;
    logic                      bge;
    logic [AMP_W-1:0]          tdiff;
    logic [33:0]               map_sum;

    assign per_eff  = (per_reg == '0) ? PER_W'(1) : per_reg;
    assign p        = qc_reg[15:0];
    assign gm       = AMP_ONE - {1'b0, p};
    assign g        = p[15] ? {gm[15:0], 1'b0} : {p, 1'b0};
    assign lfsr_step = lfsr_adv(lfsr_reg);
    assign rnd      = lfsr_step[31:16];

    assign shift_full = prod + $signed({{(2*MUL_W-40){1'b0}}, per_eff, 16'd0});

    assign lo_c  = ({8'd0, lob_reg} > ONE_EXT) ? 18'(ONE_EXT) : {1'b0, lob_reg};
    assign hi_c  = ({8'd0, upb_reg} > ONE_EXT) ? 18'(ONE_EXT) : {1'b0, upb_reg};
    assign bge   = (hi_c >= lo_c);
    assign bdiff = bge ? (hi_c - lo_c) : (lo_c - hi_c);
    assign map_sum = 34'(prod) + 34'd32768;
    assign rnd_map = 18'(map_sum >> 16);

    assign tdiff = (rom_data >= tlo_reg) ? (rom_data - tlo_reg) : (tlo_reg - rom_data);

    assign old_tgt   = 20'(span_reg) + $signed({3'd0, base_reg});
    assign span_hold = np_reg ? $signed({4'd0, rnd}) : 20'(span_reg);
    assign prod_adj  = (prod < 0) ? (prod + 52'sd65535) : prod;
    assign prod_q    = prod_adj >>> 16;

    assign np_lim = {({1'b0, div_q[DIV_DW-1:16]} + 34'd1), 16'd0};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_IDLE:
            begin
                mul_a = MUL_W'(phase_reg);
                mul_b = $signed({2'd0, per_eff});
            end
            ST_SHAPE:
            begin
                mul_a = $signed({9'd0, g});
                mul_b = MUL_W'(TABLE_ENTRIES);
            end
            ST_THI:
            begin
                mul_a = $signed({9'd0, tdiff});
                mul_b = $signed({10'd0, fr_reg});
            end
            ST_SLMUL:
            begin
                mul_a = MUL_W'(span_reg);
                mul_b = $signed({10'd0, p});
            end
            // product held while a result waits in ST_OUT
            ST_MAP, ST_OUT:
            begin
                mul_a = $signed({8'd0, bdiff});
                mul_b = $signed({9'd0, amp_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = {1'b0, t_reg, 16'd0} + DIV_DW'(shift_full[40:0]);
        if (state_reg == ST_DIVC)
            div_dividend = {1'b0, prev_reg, 16'd0} + DIV_DW'(shift_reg);
        if (state_reg == ST_SHIFT)
            div_start = 1'b1;
        if (state_reg == ST_DIVC && div_done)
            div_start = 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        wave_next  = wave_reg;
        per_next   = per_reg;
        phase_next = phase_reg;
        lob_next   = lob_reg;
        upb_next   = upb_reg;
        t_next     = t_reg;
        prev_next  = prev_reg;
        shift_next = shift_reg;
        qc_next    = qc_reg;
        rcnz_next  = rcnz_reg;
        np_next    = np_reg;
        span_next  = span_reg;
        base_next  = base_reg;
        lfsr_next  = lfsr_reg;
        amp_next   = amp_reg;
        idx_next   = idx_reg;
        fr_next    = fr_reg;
        tlo_next   = tlo_reg;
        ge_next    = ge_reg;
        ov_next    = ov_reg;
        val_next   = val_reg;
        onp_next   = onp_reg;

        if (cfg.valid)
        begin
            case (cfg.index)
                REG_WAVEFORM:     wave_next  = cfg.data[3:0];
                REG_PERIOD_SCALE: per_next   = cfg.data[PER_W-1:0];
                REG_PHASE_OFFSET: phase_next = $signed(cfg.data[16:0]);
                REG_LOWER_BOUND:  lob_next   = cfg.data[16:0];
                REG_UPPER_BOUND:  upb_next   = cfg.data[16:0];
                default:          ;
            endcase
        end

        if (ov_reg && dout.ready)
            ov_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (din.valid)
                begin
                    t_next     = din.time_in_bars;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                shift_next = shift_full[40:0];
                state_next = ST_DIVC;
            end
            ST_DIVC:
            begin
                if (div_done)
                begin
                    qc_next    = div_q;
                    rcnz_next  = (div_r != '0);
                    state_next = ST_DIVP;
                end
            end
            ST_DIVP:
            begin
                if (div_done)
                begin
                    np_next = ({1'b0, qc_reg} > np_lim) ||
                              (({1'b0, qc_reg} == np_lim) && rcnz_reg);
                    state_next = ST_SHAPE;
                end
            end
            ST_SHAPE:
            begin
                state_next = ST_MAP;
                case (wave_reg)
                    WAVE_SINE, WAVE_EXP: state_next = ST_TIDX;
                    WAVE_TRIANGLE:       amp_next = g;
                    WAVE_SAW:            amp_next = {1'b0, p};
                    WAVE_REV_SAW:        amp_next = AMP_ONE - {1'b0, p};
                    WAVE_SQUARE:         amp_next = (p > 16'd32768) ? AMP_ONE : '0;
                    WAVE_RND_HOLD:
                    begin
                        if (np_reg)
                        begin
                            span_next = $signed({2'd0, rnd});
                            lfsr_next = lfsr_step;
                        end
                        amp_next = clamp_amp(span_hold);
                    end
                    WAVE_RND_SLID:
                    begin
                        if (np_reg)
                        begin
                            base_next = clamp_amp(old_tgt);
                            span_next = 18'($signed({4'd0, rnd}) -
                                            $signed({3'd0, clamp_amp(old_tgt)}));
                            lfsr_next = lfsr_step;
                        end
                        state_next = ST_SLMUL;
                    end
                    WAVE_RND_TICK:
                    begin
                        amp_next  = {1'b0, rnd};
                        lfsr_next = lfsr_step;
                    end
                    WAVE_PULSE_UP:       amp_next = np_reg ? AMP_ONE : '0;
                    WAVE_PULSE_DN:       amp_next = np_reg ? '0 : AMP_ONE;
                    default:             amp_next = '0;
                endcase
            end
            ST_TIDX:
            begin
                idx_next   = prod[16 +: IW];
                fr_next    = prod[15:0];
                state_next = ST_TLO;
            end
            ST_TLO:
            begin
                tlo_next = rom_data;
                if (idx_reg == IW'(TABLE_ENTRIES))
                begin
                    amp_next   = rom_data;
                    state_next = ST_MAP;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_THI;
                end
            end
            ST_THI:
            begin
                ge_next    = (rom_data >= tlo_reg);
                state_next = ST_TINT;
            end
            ST_TINT:
            begin
                amp_next   = ge_reg ? (tlo_reg + prod[32:16]) : (tlo_reg - prod[32:16]);
                state_next = ST_MAP;
            end
            ST_SLMUL:
            begin
                state_next = ST_SLADD;
            end
            ST_SLADD:
            begin
                amp_next   = clamp_amp($signed({3'd0, base_reg}) + prod_q[19:0]);
                state_next = ST_MAP;
            end
            ST_MAP:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ov_reg || dout.ready)
                begin
                    ov_next    = 1'b1;
                    val_next   = bge ? (lo_c + rnd_map) : (lo_c - rnd_map);
                    onp_next   = np_reg;
                    prev_next  = t_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wave_reg  <= WAVE_SINE;
            per_reg   <= PER_W'(65536);
            phase_reg <= '0;
            lob_reg   <= '0;
            upb_reg   <= 17'd65536;
            prev_reg  <= '0;
            span_reg  <= '0;
            base_reg  <= '0;
            lfsr_reg  <= LFSR_SEED;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wave_reg  <= wave_next;
            per_reg   <= per_next;
            phase_reg <= phase_next;
            lob_reg   <= lob_next;
            upb_reg   <= upb_next;
            prev_reg  <= prev_next;
            span_reg  <= span_next;
            base_reg  <= base_next;
            lfsr_reg  <= lfsr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        shift_reg <= shift_next;
        qc_reg    <= qc_next;
        rcnz_reg  <= rcnz_next;
        np_reg    <= np_next;
        amp_reg   <= amp_next;
        idx_reg   <= idx_next;
        fr_reg    <= fr_next;
        tlo_reg   <= tlo_next;
        ge_reg    <= ge_next;
        val_reg   <= val_next;
        onp_reg   <= onp_next;
    end

    lfo_mult u_mult (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    lfo_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (per_eff),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    lfo_shape_rom #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_rom (
        .sel_exp (wave_reg == WAVE_EXP),
        .idx     (idx_reg),
        .data    (rom_data)
    );

    assign din.ready       = (state_reg == ST_IDLE);
    assign cfg.ready       = 1'b1;
    assign dout.valid      = ov_reg;
    assign dout.value      = VW'(val_reg);
    assign dout.new_period = onp_reg;

endmodule

@@ design/lfo_checker.sv @@
module lfo_checker
    import lfo_pkg::*;
#(
    parameter int VW = 17
)
(
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input logic [VW-1:0] out_value
);

    localparam logic [VW:0] VAL_MAX = (VW+1)'(1) << (VW - 1);

    // one item in flight: no second item straight after an accepted one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted twice in a row");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value))
        else $error("result dropped or changed while stalled");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> {1'b0, out_value} <= VAL_MAX)
        else $error("value above 1.0");

    // the result needs the divider: never right after acceptance
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result too soon after item");

endmodule

bind lfo_waveform_generator lfo_checker #(
    .VW (VALUE_FRAC_BITS + 1)
) u_lfo_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .out_value (dout.value)
);

@@ sim/lfo_waveform_checker.sv @@
`timescale 1ns / 100ps

module lfo_waveform_checker
    import lfo_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    lfo_in_if    din,
    lfo_out_if   dout,
    lfo_cfg_if   cfg,
    output int   errors,
    output int   pending,
    output int   results_seen,
    output int   period_starts
);

    typedef struct packed {
        logic [AMP_W-1:0] value;
        logic             new_period;
    } lfo_result_t;

    lfo_result_t expected_q[$];

    // predictor copy of the registers and state
    logic [3:0]          wave_sel;
    logic [PER_W-1:0]    period_reg;
    logic signed [16:0]  phase_reg;
    logic [16:0]         lower_reg;
    logic [16:0]         upper_reg;
    logic [31:0]         last_time;
    int                  hold_span;
    int                  hold_base;
    logic [31:0]         noise;
    int unsigned         sine_lut [0:256];
    int unsigned         exp_lut [0:256];

    function automatic int unsigned sine_point(longint unsigned k);
        longint unsigned ang, ang2, term, s, sq;
        longint sum;
        ang  = (PI_Q30 * k) / 512;
        ang2 = (ang * ang) >> 30;
        term = ang;
        sum  = longint'(ang);
        for (int n = 1; n <= 7; n++)
        begin
            term = ((term * ang2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        s  = longint'(sum);
        sq = (s * s + (64'd1 << 43)) >> 44;
        return (sq > 65536) ? 65536 : int'(sq);
    endfunction

    function automatic longint unsigned exp_series(longint unsigned k);
        longint unsigned x, term, sum;
        x    = (k << 30) / 256;
        term = Q30_ONE;
        sum  = Q30_ONE;
        for (int n = 1; n <= 16; n++)
        begin
            term = ((term * x) >> 30) / longint'(n);
            sum  = sum + term;
        end
        return sum;
    endfunction

    function automatic int unsigned lut_interp(bit use_exp, int unsigned g);
        int unsigned t, i, fr, lo, hi;
        t  = g * 256;
        i  = t >> 16;
        fr = t & 32'hFFFF;
        if (i >= 256)
            return use_exp ? exp_lut[256] : sine_lut[256];
        lo = use_exp ? exp_lut[i] : sine_lut[i];
        hi = use_exp ? exp_lut[i + 1] : sine_lut[i + 1];
        if (hi >= lo)
            return lo + int'((longint'(hi - lo) * fr) >> 16);
        return lo - int'((longint'(lo - hi) * fr) >> 16);
    endfunction

    function automatic int unsigned noise_draw();
        noise = {1'b0, noise[31:1]} ^ (noise[0] ? 32'h8020_0003 : 32'd0);
        return noise[31:16];
    endfunction

    function automatic int unsigned shape(int unsigned p, bit np);
        int unsigned g;
        int          old_target, target;
        longint      v;
        g = (p < 32768) ? 2 * p : 2 * (65536 - p);
        case (wave_sel)
            WAVE_SINE:     return lut_interp(1'b0, g);
            WAVE_TRIANGLE: return g;
            WAVE_SAW:      return p;
            WAVE_REV_SAW:  return 65536 - p;
            WAVE_SQUARE:   return (p > 32768) ? 65536 : 0;
            WAVE_EXP:      return lut_interp(1'b1, g);
            WAVE_RND_HOLD:
            begin
                if (np)
                    hold_span = int'(noise_draw());
                return (hold_span < 0) ? 0 : ((hold_span > 65536) ? 65536 : hold_span);
            end
            WAVE_RND_SLID:
            begin
                if (np)
                begin
                    old_target = hold_span + hold_base;
                    target     = int'(noise_draw());
                    if (old_target < 0)
                        old_target = 0;
                    if (old_target > 65536)
                        old_target = 65536;
                    hold_span = target - old_target;
                    hold_base = old_target;
                end
                v = longint'(hold_base) + (longint'(p) * longint'(hold_span)) / 65536;
                if (v < 0)
                    v = 0;
                if (v > 65536)
                    v = 65536;
                return int'(v);
            end
            WAVE_RND_TICK: return noise_draw();
            WAVE_PULSE_UP: return np ? 65536 : 0;
            WAVE_PULSE_DN: return np ? 0 : 65536;
            default:       return 0;
        endcase
    endfunction

    function automatic lfo_result_t predict_tick(logic [31:0] t);
        longint unsigned per, len, acc_now, acc_prev;
        longint          shift;
        int unsigned     p, lo, hi, amp, v;
        bit              np;
        lfo_result_t     r;
        per      = (period_reg == 0) ? 1 : period_reg;
        len      = per << 16;
        shift    = longint'(phase_reg) * longint'(per) + longint'(len);
        acc_now  = longint'({t, 16'h0}) + shift;
        acc_prev = longint'({last_time, 16'h0}) + shift;
        p        = int'((acc_now % len) / per) & 32'hFFFF;
        np       = acc_now > (acc_prev / len + 1) * len;
        lo       = (lower_reg > 65536) ? 65536 : lower_reg;
        hi       = (upper_reg > 65536) ? 65536 : upper_reg;
        amp      = shape(p, np);
        if (hi >= lo)
            v = lo + int'((longint'(hi - lo) * amp + 32768) >> 16);
        else
            v = lo - int'((longint'(lo - hi) * amp + 32768) >> 16);
        last_time      = t;
        r.value        = v[AMP_W-1:0];
        r.new_period   = np;
        return r;
    endfunction

    initial
    begin
        longint unsigned den, num, e;
        den = exp_series(256) - Q30_ONE;
        for (int k = 0; k <= 256; k++)
        begin
            num         = (exp_series(k) - Q30_ONE) << 16;
            e           = (num + den / 2) / den;
            sine_lut[k] = sine_point(k);
            exp_lut[k]  = (e > 65536) ? 65536 : int'(e);
        end
    end

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        lfo_result_t want;
        int          bad;
        bad = 0;
        if (!rst_n)
        begin
            wave_sel      <= WAVE_SINE;
            period_reg    <= 24'd65536;
            phase_reg     <= '0;
            lower_reg     <= '0;
            upper_reg     <= 17'd65536;
            last_time     = '0;
            hold_span     = 0;
            hold_base     = 0;
            noise         = LFSR_SEED;
            errors        <= 0;
            results_seen  <= 0;
            period_starts <= 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_WAVEFORM:     wave_sel   <= cfg.data[3:0];
                    REG_PERIOD_SCALE: period_reg <= cfg.data[PER_W-1:0];
                    REG_PHASE_OFFSET: phase_reg  <= cfg.data[16:0];
                    REG_LOWER_BOUND:  lower_reg  <= cfg.data[16:0];
                    REG_UPPER_BOUND:  upper_reg  <= cfg.data[16:0];
                    default: ;
                endcase
            end
            if (dout.valid && dout.ready)
            begin
                results_seen <= results_seen + 1;
                if (dout.new_period)
                    period_starts <= period_starts + 1;
                if (expected_q.size() == 0)
                begin
                    $error("unexpected item on dout: value %0d new_period %0d",
                           dout.value, dout.new_period);
                    bad++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (dout.value !== want.value)
                    begin
                        $error("value: expected %0d, got %0d", want.value, dout.value);
                        bad++;
                    end
                    if (dout.new_period !== want.new_period)
                    begin
                        $error("new_period: expected %0d, got %0d",
                               want.new_period, dout.new_period);
                        bad++;
                    end
                end
                errors <= errors + bad;
            end
            if (din.valid && din.ready)
                expected_q.push_back(predict_tick(din.time_in_bars));
        end
    end

endmodule

@@ sim/lfo_waveform_generator_test.sv @@
`timescale 1ns / 100ps

module lfo_waveform_generator_test;
    import lfo_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int   errors, pending, results_seen, period_starts;
    int   ticks_sent;
    int   idle_cycles;
    bit   bursty;
    int   hold_requests;
    int   holds_served;
    logic [31:0] now_bars;

    lfo_in_if  din ();
    lfo_out_if #(.VW(17)) dout ();
    lfo_cfg_if cfg ();

    lfo_waveform_generator i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .dout  (dout),
        .cfg   (cfg)
    );

    lfo_waveform_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .din           (din),
        .dout          (dout),
        .cfg           (cfg),
        .errors        (errors),
        .pending       (pending),
        .results_seen  (results_seen),
        .period_starts (period_starts)
    );

    initial
        clk = 1'b0;
    always
        #10 clk = ~clk;

    // watchdog: cycles with no accepted item on any channel
    always @(posedge clk)
    begin
        if ((din.valid && din.ready) || (dout.valid && dout.ready) || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no progress for %0d cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial
    begin
        int n;
        holds_served = 0;
        dout.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (holds_served != hold_requests)
            begin
                dout.ready <= 1'b0;
                for (n = 0; n < 600; n++)
                    @(posedge clk);
                holds_served++;
            end
            else if (bursty && $urandom_range(0, 2) == 0)
            begin
                dout.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                dout.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    task automatic send_tick(logic [31:0] t);
        if (bursty && $urandom_range(0, 3) == 0)
        begin
            din.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        din.valid        <= 1'b1;
        din.time_in_bars <= t;
        @(posedge clk);
        while (!(din.valid && din.ready))
            @(posedge clk);
        ticks_sent++;
    endtask

    task automatic quiesce();
        din.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!(cfg.valid && cfg.ready))
            @(posedge clk);
    endtask

    task automatic reg_done();
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // random settings, extremes mixed in
    task automatic pick_settings(output logic [23:0] per);
        logic [23:0] junk;
        junk = 24'($urandom);
        case ($urandom_range(0, 5))
            0:       per = 24'd0;
            1:       per = 24'd1;
            2:       per = 24'hFFFFFF;
            3:       per = 24'($urandom_range(2, 4096));
            default: per = 24'($urandom_range(4096, 24'h40000));
        endcase
        reg_write(REG_WAVEFORM, {junk[23:4],
            ($urandom_range(0, 9) == 0) ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10))});
        reg_write(REG_PERIOD_SCALE, per);
        case ($urandom_range(0, 4))
            0:       reg_write(REG_PHASE_OFFSET, {junk[23:17], 17'h18000});
            1:       reg_write(REG_PHASE_OFFSET, {junk[23:17], 17'h08000});
            default: reg_write(REG_PHASE_OFFSET, 24'($urandom));
        endcase
        reg_write(REG_LOWER_BOUND, {junk[23:17],
            ($urandom_range(0, 5) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536))});
        reg_write(REG_UPPER_BOUND, {junk[23:17],
            ($urandom_range(0, 5) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536))});
        reg_done();
    endtask

    initial
    begin
        logic [23:0] per;
        rst_n            = 1'b0;
        din.valid        = 1'b0;
        din.time_in_bars = '0;
        cfg.valid        = 1'b0;
        cfg.index        = '0;
        cfg.data         = '0;
        bursty           = 1'b0;
        hold_requests    = 0;
        ticks_sent       = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: defaults, then each waveform code across a period edge
        send_tick(32'h0000_0000);
        send_tick(32'h0000_8000);
        send_tick(32'h0001_0001);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'h0000_4000);   // time running backwards
        quiesce();
        reg_write(REG_PERIOD_SCALE, 24'h004000);
        reg_write(REG_PHASE_OFFSET, 24'h018000);
        reg_write(REG_LOWER_BOUND, 24'h01FFFF);   // clamped to 1.0
        reg_write(REG_UPPER_BOUND, 24'h000100);   // inverted mapping
        reg_done();
        now_bars = 32'h0000_1000;
        for (int w = 0; w < 16; w++)
        begin
            quiesce();
            reg_write(REG_WAVEFORM, 24'(w));
            reg_done();
            now_bars = now_bars + 32'h0000_4800;
            send_tick(now_bars);
        end
        quiesce();
        reg_write(REG_PERIOD_SCALE, 24'd0);
        reg_done();
        send_tick(32'h0000_0003);
        quiesce();

        // random phases; phase 1 carries the long result stall
        for (int ph = 0; ph < 10; ph++)
        begin
            bursty = (ph < 8);
            pick_settings(per);
            if (ph == 1)
                hold_requests++;
            now_bars = $urandom;
            for (int i = 0; i < 80; i++)
            begin
                case ($urandom_range(0, 19))
                    0:       now_bars = $urandom;
                    1:       now_bars = now_bars - $urandom_range(0, 32'(per) + 1);
                    default: now_bars = now_bars + $urandom_range(0, 32'(per) / 3 + 2);
                endcase
                send_tick(now_bars);
            end
            quiesce();
        end

        $display("%0d ticks sent, %0d results checked, %0d with a period start",
                 ticks_sent, results_seen, period_starts);
        $display("all waveform codes, period and bound extremes, stalls and gaps on both sides");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
design/lfo_pkg.sv
design/lfo_if.sv
design/lfo_divider.sv
design/lfo_mult.sv
design/lfo_shape_rom.sv
design/lfo_waveform_generator.sv
design/lfo_checker.sv
sim/lfo_waveform_checker.sv
sim/lfo_waveform_generator_test.sv
